/* src/slotted_page_store_assert.svh */
// assertion macros shared by the slotted page store rtl
// no dependencies; included by the top level
`ifndef SLOTTED_PAGE_STORE_ASSERT_SVH
`define SLOTTED_PAGE_STORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define SPS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sps_pkg.sv */
// slotted page store: shared constants, codes and structs
// no dependencies; used by every module of the block except sps_ram
package sps_pkg;

    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int SLOT_BYTES_DEF   = 8;
    localparam int MAX_SLOTS_DEF    = 512;

    localparam int KIND_W   = 3;
    localparam int LEN_W    = 13;
    localparam int DATA_W   = 8;
    localparam int SLOT_W   = 9;
    localparam int BOFF_W   = 12;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 13;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR        = 3'd0,
        KIND_INSERT_BEGIN = 3'd1,
        KIND_INSERT_BYTE  = 3'd2,
        KIND_GET          = 3'd3,
        KIND_DELETE       = 3'd4,
        KIND_READ_BYTE    = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_BAD_SLOT   = 2'd2,
        ST_UNEXPECTED = 2'd3
    } status_t;

    // request state between the accept stage and the result register
    typedef struct packed {
        logic                is_get;
        logic                is_read;
        status_t             status;
        logic [SLOT_W-1:0]   slot_number;
    } stage_t;

    // registered memory read data for the request in the stage
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              deleted;
        logic [DATA_W-1:0] data;
    } rdata_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot_number;
        logic [OFF_W-1:0]  record_offset;
        logic [LEN_W-1:0]  found_length;
        logic [DATA_W-1:0] read_data;
    } result_t;

endpackage

/* src/sps_ram.sv */
// generic single write port ram with registered read
// no dependencies; used for page bytes and the slot directory
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sps_ctrl.sv */
// slotted page store: page pointers, request decode and the memories
// depends on sps_pkg and sps_ram
module sps_ctrl #(
    parameter int PAGE_BYTES   = sps_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = sps_pkg::HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = sps_pkg::SLOT_BYTES_DEF,
    parameter int MAX_SLOTS    = sps_pkg::MAX_SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sps_pkg::KIND_W-1:0]  kind,
    input  logic [sps_pkg::LEN_W-1:0]   record_length,
    input  logic [sps_pkg::DATA_W-1:0]  data_byte,
    input  logic [sps_pkg::SLOT_W-1:0]  slot_index,
    input  logic [sps_pkg::BOFF_W-1:0]  byte_offset,
    input  logic                        s1_take,
    output logic                        s1_valid,
    output sps_pkg::stage_t             s1,
    output sps_pkg::rdata_t             rd
);
    import sps_pkg::*;

    localparam int PW    = $clog2(PAGE_BYTES + 1);
    localparam int PAW   = $clog2(PAGE_BYTES);
    localparam int TW    = $clog2(MAX_SLOTS + 1);
    localparam int SAW   = $clog2(MAX_SLOTS);
    localparam int SW    = ((PW > LEN_W) ? PW : LEN_W) + 2;
    localparam int DIR_W = OFF_W + LEN_W;

    logic          page_is_data_reg, page_is_data_next;
    logic [TW-1:0] slot_total_reg, slot_total_next;
    logic [PW-1:0] dir_end_reg, dir_end_next;
    logic [PW-1:0] payload_start_reg, payload_start_next;
    logic [PW-1:0] write_pointer_reg, write_pointer_next;
    logic [PW-1:0] bytes_pending_reg, bytes_pending_next;
    logic          s1_valid_reg, s1_valid_next;
    stage_t        s1_reg, s1_next;

    logic             accept;
    logic [SW-1:0]    room_sum;
    logic             begin_fail;
    logic             byte_fail;
    logic             slot_bad;
    logic             boff_bad;
    logic [PW-1:0]    new_start;
    logic [TW+SLOT_W-1:0] sidx_wide;
    logic [TW+SLOT_W-1:0] total_wide;
    logic [SAW+SLOT_W-1:0] sidx_addr_ext;
    logic [PAW+BOFF_W-1:0] boff_addr_ext;
    logic [PW+OFF_W-1:0]   new_start_ext;

    logic             page_we;
    logic             dir_we;
    logic             del_we;
    logic [SAW-1:0]   del_waddr;
    logic             del_wdata;
    logic [DATA_W-1:0] page_rdata;
    logic [DIR_W-1:0]  dir_rdata;
    logic              del_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !s1_valid_reg || s1_take;

    assign room_sum = SW'(dir_end_reg) + SW'(SLOT_BYTES) + SW'(record_length);
    assign begin_fail = !page_is_data_reg
                     || (SW'(record_length) > SW'(PAGE_BYTES))
                     || (slot_total_reg >= TW'(MAX_SLOTS))
                     || (room_sum > SW'(payload_start_reg));
    assign byte_fail = (bytes_pending_reg == '0) || (write_pointer_reg >= PW'(PAGE_BYTES));
    assign sidx_wide  = (TW+SLOT_W)'(slot_index);
    assign total_wide = (TW+SLOT_W)'(slot_total_reg);
    assign slot_bad   = (sidx_wide >= total_wide) || (sidx_wide >= (TW+SLOT_W)'(MAX_SLOTS));
    assign boff_bad   = (PW+BOFF_W)'(byte_offset) >= (PW+BOFF_W)'(PAGE_BYTES);
    assign new_start  = payload_start_reg - PW'(record_length);

    assign sidx_addr_ext = (SAW+SLOT_W)'(slot_index);
    assign boff_addr_ext = (PAW+BOFF_W)'(byte_offset);
    assign new_start_ext = (PW+OFF_W)'(new_start);

    always_comb begin
        page_is_data_next  = cfg_we ? cfg_wdata : page_is_data_reg;
        slot_total_next    = slot_total_reg;
        dir_end_next       = dir_end_reg;
        payload_start_next = payload_start_reg;
        write_pointer_next = write_pointer_reg;
        bytes_pending_next = bytes_pending_reg;
        s1_valid_next      = s1_valid_reg;
        s1_next            = s1_reg;
        page_we            = 1'b0;
        dir_we             = 1'b0;
        del_we             = 1'b0;
        del_waddr          = sidx_addr_ext[SAW-1:0];
        del_wdata          = 1'b1;

        if (s1_take) begin
            s1_valid_next = 1'b0;
        end
        if (accept) begin
            s1_valid_next       = 1'b1;
            s1_next.is_get      = 1'b0;
            s1_next.is_read     = 1'b0;
            s1_next.status      = ST_OK;
            s1_next.slot_number = '0;
            case (kind_t'(kind))
                KIND_CLEAR: begin
                    slot_total_next    = '0;
                    dir_end_next       = PW'(HEADER_BYTES);
                    payload_start_next = PW'(PAGE_BYTES);
                    write_pointer_next = '0;
                    bytes_pending_next = '0;
                end
                KIND_INSERT_BEGIN: begin
                    if (begin_fail) begin
                        s1_next.status     = ST_NO_ROOM;
                        bytes_pending_next = '0;
                    end else begin
                        dir_we              = 1'b1;
                        del_we              = 1'b1;
                        del_waddr           = slot_total_reg[SAW-1:0];
                        del_wdata           = 1'b0;
                        s1_next.slot_number = total_wide[SLOT_W-1:0];
                        slot_total_next     = slot_total_reg + 1'b1;
                        dir_end_next        = dir_end_reg + PW'(SLOT_BYTES);
                        payload_start_next  = new_start;
                        write_pointer_next  = new_start;
                        bytes_pending_next  = PW'(record_length);
                    end
                end
                KIND_INSERT_BYTE: begin
                    if (byte_fail) begin
                        s1_next.status = ST_UNEXPECTED;
                    end else begin
                        page_we            = 1'b1;
                        write_pointer_next = write_pointer_reg + 1'b1;
                        bytes_pending_next = bytes_pending_reg - 1'b1;
                    end
                end
                KIND_GET: begin
                    if (slot_bad) begin
                        s1_next.status = ST_BAD_SLOT;
                    end else begin
                        // tombstone is checked once the delete-flag ram read returns
                        s1_next.is_get = 1'b1;
                    end
                end
                KIND_DELETE: begin
                    if (slot_bad) begin
                        s1_next.status = ST_BAD_SLOT;
                    end else begin
                        del_we = 1'b1;
                    end
                end
                KIND_READ_BYTE: begin
                    if (boff_bad) begin
                        s1_next.status = ST_BAD_SLOT;
                    end else begin
                        s1_next.is_read = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_is_data_reg  <= 1'b1;
            slot_total_reg    <= '0;
            dir_end_reg       <= PW'(HEADER_BYTES);
            payload_start_reg <= PW'(PAGE_BYTES);
            write_pointer_reg <= '0;
            bytes_pending_reg <= '0;
            s1_valid_reg      <= 1'b0;
        end else begin
            page_is_data_reg  <= page_is_data_next;
            slot_total_reg    <= slot_total_next;
            dir_end_reg       <= dir_end_next;
            payload_start_reg <= payload_start_next;
            write_pointer_reg <= write_pointer_next;
            bytes_pending_reg <= bytes_pending_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
    end

    // reads only on accept, so read data holds while the stage is stalled
    sps_ram #(.WIDTH(DATA_W), .DEPTH(PAGE_BYTES)) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (write_pointer_reg[PAW-1:0]),
        .wdata (data_byte),
        .re    (accept),
        .raddr (boff_addr_ext[PAW-1:0]),
        .rdata (page_rdata)
    );

    sps_ram #(.WIDTH(DIR_W), .DEPTH(MAX_SLOTS)) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_we),
        .waddr (slot_total_reg[SAW-1:0]),
        .wdata ({new_start_ext[OFF_W-1:0], record_length}),
        .re    (accept),
        .raddr (sidx_addr_ext[SAW-1:0]),
        .rdata (dir_rdata)
    );

    sps_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_del_ram (
        .aclk  (aclk),
        .we    (del_we),
        .waddr (del_waddr),
        .wdata (del_wdata),
        .re    (accept),
        .raddr (sidx_addr_ext[SAW-1:0]),
        .rdata (del_rdata)
    );

    assign rd.offset  = dir_rdata[DIR_W-1:LEN_W];
    assign rd.length  = dir_rdata[LEN_W-1:0];
    assign rd.deleted = del_rdata;
    assign rd.data    = page_rdata;

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

/* src/sps_resp.sv */
// slotted page store: result assembly and the output register
// depends on sps_pkg
module sps_resp (
    input  logic            aclk,
    input  logic            aresetn,
    input  sps_pkg::stage_t s1,
    input  logic            s1_valid,
    input  sps_pkg::rdata_t rd,
    input  logic            m_tready,
    output logic            s1_take,
    output logic            m_valid,
    output sps_pkg::result_t res
);
    import sps_pkg::*;

    logic    m_valid_reg, m_valid_next;
    result_t res_reg, res_next;

    assign s1_take = !m_valid_reg || m_tready;

    always_comb begin
        res_next.status        = s1.status;
        res_next.slot_number   = s1.slot_number;
        res_next.record_offset = '0;
        res_next.found_length  = '0;
        res_next.read_data     = '0;
        if (s1.is_get) begin
            if (rd.deleted) begin
                res_next.status = ST_BAD_SLOT;
            end else begin
                res_next.record_offset = rd.offset;
                res_next.found_length  = rd.length;
            end
        end
        if (s1.is_read) begin
            res_next.read_data = rd.data;
        end
        m_valid_next = s1_take ? s1_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take && s1_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

endmodule

/* src/slotted_page_store.sv */
// a request and its registered ram reads move into the middle stage on accept, and the
// result register is loaded from that stage when it is empty or its result is being taken
// throughput: one request per cycle; the registered reads of page and slot rams set the depth
// a held result stalls the input (s_tready low) only once the middle stage is also full
// reset (aresetn low, synchronous): pointers and slot count back to an empty page,
// page type register back to data, pipeline emptied; ram contents are kept
`include "slotted_page_store_assert.svh"

module slotted_page_store #(
    parameter int PAGE_BYTES   = sps_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = sps_pkg::HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = sps_pkg::SLOT_BYTES_DEF,
    parameter int MAX_SLOTS    = sps_pkg::MAX_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // kind
    input  logic [sps_pkg::KIND_W-1:0]    s_tuser,
    // record_length, data_byte, slot_index, byte_offset, zero fill
    input  logic [sps_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, slot_number, record_offset, found_length, read_data, zero fill
    output logic [sps_pkg::M_TDATA_W-1:0] m_tdata
);
    import sps_pkg::*;

    logic    accept;
    logic    s1_take;
    logic    s1_valid;
    stage_t  s1;
    rdata_t  rd;
    result_t res;

    assign accept = s_tvalid && s_tready;

    sps_ctrl #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .SLOT_BYTES   (SLOT_BYTES),
        .MAX_SLOTS    (MAX_SLOTS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .kind          (s_tuser),
        .record_length (s_tdata[12:0]),
        .data_byte     (s_tdata[20:13]),
        .slot_index    (s_tdata[29:21]),
        .byte_offset   (s_tdata[41:30]),
        .s1_take       (s1_take),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .rd            (rd)
    );

    sps_resp u_resp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1),
        .s1_valid (s1_valid),
        .rd       (rd),
        .m_tready (m_tready),
        .s1_take  (s1_take),
        .m_valid  (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {3'b000, res.read_data, res.found_length, res.record_offset,
                      res.slot_number, res.status};

    `SPS_ASSERT_NEXT(a_accept_fills_stage, aclk, aresetn, accept, s1_valid, "accepted request lost before the result stage")
    `SPS_ASSERT_NEXT(a_stage_holds, aclk, aresetn, s1_valid && !s1_take, s1_valid && $stable(s1), "stalled request changed in the middle stage")
    `SPS_ASSERT_IMPLY(a_error_fields_zero, aclk, aresetn, m_tvalid && res.status != ST_OK, res.slot_number == '0 && res.record_offset == '0 && res.found_length == '0 && res.read_data == '0, "failed request carries non-zero fields")

endmodule
